// ===== rtl/mapc_pkg.sv =====
package mapc_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int SPEED_W     = 24;
   localparam int THR_W       = 16;
   localparam int PHASE_W     = 2;

   localparam int REQ_DATA_W  = ((2 * WHEEL_COUNT * SPEED_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = WHEEL_COUNT * PHASE_W + 3;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 2;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [THR_W-1:0]   thr_type;
   typedef logic [SPEED_W-1:0] mag_type;

   localparam phase_type PH_STOP   = 2'd0;
   localparam phase_type PH_START  = 2'd1;
   localparam phase_type PH_STABLE = 2'd2;
   localparam phase_type PH_DOWN   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_HOLD = 2'd2;

   localparam thr_type DELTA_THR_RESET  = 16'd77;
   localparam thr_type STOP_THR_RESET   = 16'd256;
   localparam thr_type BOOST_HOLD_RESET = 16'd300;

   typedef struct packed {
      logic boost;
      logic starting;
      logic slowing;
   } flags_type;

endpackage

// ===== rtl/mapc_lane.sv =====
module mapc_lane (
   input  logic signed [mapc_pkg::SPEED_W-1:0] ref_speed,
   input  logic signed [mapc_pkg::SPEED_W-1:0] prev_speed,
   input  mapc_pkg::thr_type                   delta_threshold,
   input  mapc_pkg::thr_type                   stop_threshold,
   output mapc_pkg::phase_type                 phase
);

   mapc_pkg::mag_type                  ref_mag;
   mapc_pkg::mag_type                  prev_mag;
   logic signed [mapc_pkg::SPEED_W:0]  rise;
   logic signed [mapc_pkg::SPEED_W:0]  fall;
   logic signed [mapc_pkg::SPEED_W:0]  delta_ext;

   // The most negative reference maps to 2^23, which still fits unsigned.
   assign ref_mag   = ref_speed[mapc_pkg::SPEED_W-1] ? (~ref_speed + 1'b1) : ref_speed;
   assign prev_mag  = prev_speed[mapc_pkg::SPEED_W-1] ? (~prev_speed + 1'b1) : prev_speed;
   assign rise      = $signed({1'b0, ref_mag}) - $signed({1'b0, prev_mag});
   assign fall      = $signed({1'b0, prev_mag}) - $signed({1'b0, ref_mag});
   assign delta_ext = $signed({{(mapc_pkg::SPEED_W + 1 - mapc_pkg::THR_W){1'b0}},
                               delta_threshold});

   always_comb begin
      if (rise >= delta_ext) begin
         phase = mapc_pkg::PH_START;
      end else if (fall >= delta_ext) begin
         phase = mapc_pkg::PH_DOWN;
      end else if (ref_mag <= {{(mapc_pkg::SPEED_W - mapc_pkg::THR_W){1'b0}},
                               stop_threshold}) begin
         phase = mapc_pkg::PH_STOP;
      end else begin
         phase = mapc_pkg::PH_STABLE;
      end
   end

endmodule

// ===== rtl/mapc_merge.sv =====
module mapc_merge (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             step,
   input  logic [mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W-1:0] phases,
   input  mapc_pkg::thr_type                                boost_hold_ticks,
   output mapc_pkg::flags_type                              flags_next
);

   logic                boost_flag_ff;
   logic                boost_flag_in;
   mapc_pkg::thr_type   boost_timer_ff;
   mapc_pkg::thr_type   boost_timer_in;
   logic                starting_flag_ff;
   logic                starting_flag_in;
   logic                slowing_flag_ff;
   logic                slowing_flag_in;
   logic                all_start;
   logic                all_down;

   always_comb begin
      all_start = 1'b1;
      all_down  = 1'b1;
      for (int i = 0; i < mapc_pkg::WHEEL_COUNT; i++) begin
         if (phases[i*mapc_pkg::PHASE_W +: mapc_pkg::PHASE_W] != mapc_pkg::PH_START) begin
            all_start = 1'b0;
         end
         if (phases[i*mapc_pkg::PHASE_W +: mapc_pkg::PHASE_W] != mapc_pkg::PH_DOWN) begin
            all_down = 1'b0;
         end
      end
   end

   always_comb begin
      boost_timer_in = boost_timer_ff;
      if (boost_flag_ff && (boost_timer_ff >= boost_hold_ticks)) begin
         boost_timer_in = '0;
         boost_flag_in  = all_start;
      end else if (boost_flag_ff) begin
         boost_timer_in = boost_timer_ff + 1'b1;
         boost_flag_in  = 1'b1;
      end else begin
         boost_flag_in  = all_start;
      end

      starting_flag_in = starting_flag_ff;
      slowing_flag_in  = slowing_flag_ff;
      if (boost_flag_in) begin
         starting_flag_in = 1'b1;
      end else if (all_down) begin
         slowing_flag_in = 1'b1;
      end else begin
         starting_flag_in = 1'b0;
         slowing_flag_in  = 1'b0;
      end
   end

   assign flags_next.boost    = boost_flag_in;
   assign flags_next.starting = starting_flag_in;
   assign flags_next.slowing  = slowing_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         boost_flag_ff    <= 1'b0;
         boost_timer_ff   <= '0;
         starting_flag_ff <= 1'b0;
         slowing_flag_ff  <= 1'b0;
      end else if (step) begin
         boost_flag_ff    <= boost_flag_in;
         boost_timer_ff   <= boost_timer_in;
         starting_flag_ff <= starting_flag_in;
         slowing_flag_ff  <= slowing_flag_in;
      end
   end

`ifndef SYNTH
   a_timer_idle_hold: assert property (@(posedge clock) disable iff (reset)
      step && !boost_flag_ff |=> boost_timer_ff == $past(boost_timer_ff))
      else $error("boost timer moved while boost was idle");

   a_boost_implies_start: assert property (@(posedge clock) disable iff (reset)
      boost_flag_ff |-> starting_flag_ff)
      else $error("boost set without chassis starting flag");
`endif

endmodule

// ===== rtl/motor_accel_phase_classifier_core.sv =====
// Channel   Direction  Handshake                    Payload
// req       in         req_tvalid / req_tready      req_tdata: ref_wheel0..3, prev_wheel0..3
// rsp       out        rsp_tvalid / rsp_tready      rsp_tdata: phases, boost, starting, slowing
// csr       in         csr_valid / csr_ready        csr_index, csr_data
//
// One beat is accepted every cycle unless the output stalls; the output register takes its result.
// All four lanes and the boost/chassis update are combinational between input and that register.
// A stalled output register blocks input only while it is full and not being taken.
// Synchronous reset clears the boost and chassis state and loads the register defaults.
module motor_accel_phase_classifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // ref_wheel0..3 then prev_wheel0..3, 24 bits each, from bit 0 up.
   input  logic [mapc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // phase_wheel0..3 (2 bits each), boost_active, chassis_starting, chassis_slowing, zero pad.
   output logic [mapc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mapc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  mapc_pkg::thr_type                    csr_data
);

   mapc_pkg::thr_type                                  delta_thr_ff;
   mapc_pkg::thr_type                                  stop_thr_ff;
   mapc_pkg::thr_type                                  boost_hold_ff;
   logic                                               rsp_valid_ff;
   logic                                               rsp_valid_in;
   logic [mapc_pkg::RSP_DATA_W-1:0]                    rsp_data_ff;
   logic [mapc_pkg::RSP_DATA_W-1:0]                    rsp_data_in;
   logic [mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W-1:0] phases;
   mapc_pkg::flags_type                                flags_next;
   logic                                               step;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_thr_ff  <= mapc_pkg::DELTA_THR_RESET;
         stop_thr_ff   <= mapc_pkg::STOP_THR_RESET;
         boost_hold_ff <= mapc_pkg::BOOST_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mapc_pkg::CSR_DELTA_THR: begin
               delta_thr_ff <= csr_data;
            end
            mapc_pkg::CSR_STOP_THR: begin
               stop_thr_ff <= csr_data;
            end
            mapc_pkg::CSR_BOOST_HOLD: begin
               boost_hold_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < mapc_pkg::WHEEL_COUNT; i++) begin : g_lane
      mapc_lane u_lane (
         .ref_speed       (req_tdata[i*mapc_pkg::SPEED_W +: mapc_pkg::SPEED_W]),
         .prev_speed      (req_tdata[(mapc_pkg::WHEEL_COUNT + i)*mapc_pkg::SPEED_W
                                     +: mapc_pkg::SPEED_W]),
         .delta_threshold (delta_thr_ff),
         .stop_threshold  (stop_thr_ff),
         .phase           (phases[i*mapc_pkg::PHASE_W +: mapc_pkg::PHASE_W])
      );
   end

   mapc_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .phases           (phases),
      .boost_hold_ticks (boost_hold_ff),
      .flags_next       (flags_next)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W-1:0]   = phases;
      rsp_data_in[mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W]       = flags_next.boost;
      rsp_data_in[mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W + 1]   = flags_next.starting;
      rsp_data_in[mapc_pkg::WHEEL_COUNT*mapc_pkg::PHASE_W + 2]   = flags_next.slowing;
      rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("accepted beat produced no result");
`endif

endmodule

// ===== dv/motor_accel_phase_classifier_checker.sv =====
module motor_accel_phase_classifier_checker
   import mapc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  thr_type               csr_data,
   output int                    error_count,
   output int                    pending_count
);

   // Laid out like the low bits of rsp_tdata, wheel 0 phase lowest.
   typedef struct packed {
      logic                                 slowing;
      logic                                 starting;
      logic                                 boost;
      logic [WHEEL_COUNT-1:0][PHASE_W-1:0]  phase;
   } tick_verdict_t;

   thr_type       delta_thr;
   thr_type       stop_thr;
   thr_type       hold_ticks;
   logic          boost_on;
   logic [15:0]   boost_age;
   logic          start_on;
   logic          slow_on;
   int            result_no;
   tick_verdict_t awaited_verdicts [$];

   task automatic flag_error(string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   function automatic int lane_mag(mag_type raw);
      int v;
      v = int'({8'd0, raw});
      return raw[SPEED_W-1] ? (1 << SPEED_W) - v : v;
   endfunction

   function automatic phase_type lane_phase(mag_type cur, mag_type old);
      int r;
      int p;
      int d;
      r = lane_mag(cur);
      p = lane_mag(old);
      d = int'({16'd0, delta_thr});
      if (r - p >= d) return PH_START;
      if (p - r >= d) return PH_DOWN;
      if (r <= int'({16'd0, stop_thr})) return PH_STOP;
      return PH_STABLE;
   endfunction

   function automatic tick_verdict_t next_verdict(logic [REQ_DATA_W-1:0] beat);
      tick_verdict_t v;
      logic          all_rise;
      logic          all_fall;
      all_rise = 1'b1;
      all_fall = 1'b1;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         v.phase[i] = lane_phase(beat[i*SPEED_W +: SPEED_W],
                                 beat[(WHEEL_COUNT+i)*SPEED_W +: SPEED_W]);
         if (v.phase[i] != PH_START) all_rise = 1'b0;
         if (v.phase[i] != PH_DOWN) all_fall = 1'b0;
      end
      if (boost_on && boost_age >= hold_ticks) begin
         boost_age = '0;
         boost_on  = all_rise;
      end else if (boost_on) begin
         boost_age = boost_age + 1'b1;
      end else begin
         boost_on = all_rise;
      end
      if (boost_on) begin
         start_on = 1'b1;
      end else if (all_fall) begin
         slow_on = 1'b1;
      end else begin
         start_on = 1'b0;
         slow_on  = 1'b0;
      end
      v.boost    = boost_on;
      v.starting = start_on;
      v.slowing  = slow_on;
      return v;
   endfunction

   always @(posedge clock) begin : watch
      tick_verdict_t got;
      tick_verdict_t want;
      if (reset) begin
         delta_thr   = DELTA_THR_RESET;
         stop_thr    = STOP_THR_RESET;
         hold_ticks  = BOOST_HOLD_RESET;
         boost_on    = 1'b0;
         boost_age   = '0;
         start_on    = 1'b0;
         slow_on     = 1'b0;
         result_no   = 0;
         error_count = 0;
         awaited_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DELTA_THR:  delta_thr  = csr_data;
               CSR_STOP_THR:   stop_thr   = csr_data;
               CSR_BOOST_HOLD: hold_ticks = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = tick_verdict_t'(rsp_tdata[RSP_FIELD_W-1:0]);
            if (awaited_verdicts.size() == 0) begin
               flag_error($sformatf("result %0d arrived with no tick outstanding",
                                    result_no));
            end else begin
               want = awaited_verdicts.pop_front();
               for (int i = 0; i < WHEEL_COUNT; i++)
                  if (got.phase[i] !== want.phase[i])
                     flag_error($sformatf("result %0d phase_wheel%0d: expected %0d, got %0d",
                                          result_no, i, want.phase[i], got.phase[i]));
               if (got.boost !== want.boost)
                  flag_error($sformatf("result %0d boost_active: expected %0b, got %0b",
                                       result_no, want.boost, got.boost));
               if (got.starting !== want.starting)
                  flag_error($sformatf("result %0d chassis_starting: expected %0b, got %0b",
                                       result_no, want.starting, got.starting));
               if (got.slowing !== want.slowing)
                  flag_error($sformatf("result %0d chassis_slowing: expected %0b, got %0b",
                                       result_no, want.slowing, got.slowing));
            end
            result_no++;
         end
         if (req_tvalid && req_tready)
            awaited_verdicts.push_back(next_verdict(req_tdata));
      end
      pending_count = awaited_verdicts.size();
   end

endmodule

// ===== dv/tb_motor_accel_phase_classifier_core.sv =====
module tb_motor_accel_phase_classifier_core;
   import mapc_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 6;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int LIMIT_CYCLES = 300000;
   localparam int MAG_TOP      = 1 << (SPEED_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   typedef enum int {LANE_RISE, LANE_FALL, LANE_REST, LANE_CRUISE, LANE_RAW} lane_kind_t;
   typedef enum int {TICK_ALL_RISE, TICK_ALL_FALL, TICK_MIXED, TICK_NOISE} tick_kind_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   thr_type               csr_data   = '0;
   int                    error_count;
   int                    pending_count;

   bit      src_idle_en   = 1'b1;
   bit      sink_idle_en  = 1'b1;
   bit      long_hold_req = 1'b0;
   thr_type cfg_delta     = DELTA_THR_RESET;
   thr_type cfg_stop      = STOP_THR_RESET;
   mag_type lane_cur  [WHEEL_COUNT];
   mag_type lane_prev [WHEEL_COUNT];

   motor_accel_phase_classifier_core dut (.*);

   motor_accel_phase_classifier_checker checker_inst (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : rsp_sink
      int burst;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            burst = $urandom_range(1, 10);
            repeat (burst) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int pick_mag(int lo, int hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return (hi - lo > 300) ? lo + $urandom_range(0, 300) : $urandom_range(hi, lo);
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic mag_type to_raw(int mag);
      if (mag >= MAG_TOP) return mag_type'(MAG_TOP);
      return $urandom_range(0, 1) ? mag_type'(0 - mag) : mag_type'(mag);
   endfunction

   task automatic make_lane(lane_kind_t kind, output mag_type cur, output mag_type old);
      int r;
      int p;
      int d;
      int off;
      d   = int'(cfg_delta);
      off = (d > 0) ? pick_mag(0, d - 1) : 0;
      r   = 0;
      p   = 0;
      case (kind)
         LANE_RISE: begin
            p = pick_mag(0, MAG_TOP - d - 3);
            r = p + d + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
         end
         LANE_FALL: begin
            r = pick_mag(0, MAG_TOP - d - 3);
            p = r + d + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
         end
         LANE_REST:   r = pick_mag(0, int'(cfg_stop));
         LANE_CRUISE: r = pick_mag(int'(cfg_stop) + 1, MAG_TOP);
         default: ;
      endcase
      if (kind == LANE_REST || kind == LANE_CRUISE)
         p = (r + off > MAG_TOP || (r >= off && $urandom_range(0, 1))) ? r - off : r + off;
      if (kind == LANE_RAW) begin
         cur = mag_type'($urandom);
         old = mag_type'($urandom);
      end else begin
         cur = to_raw(r);
         old = to_raw(p);
      end
   endtask

   task automatic set_lanes(mag_type cur, mag_type old);
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         lane_cur[i]  = cur;
         lane_prev[i] = old;
      end
   endtask

   task automatic push_lanes();
      logic [REQ_DATA_W-1:0] beat;
      int                    gap;
      beat = '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         beat[i*SPEED_W +: SPEED_W]               = lane_cur[i];
         beat[(WHEEL_COUNT+i)*SPEED_W +: SPEED_W] = lane_prev[i];
      end
      gap = (src_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic run_ticks(int count);
      tick_kind_t mode;
      lane_kind_t kind;
      int         run_left;
      run_left = 0;
      mode     = TICK_MIXED;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: mode = TICK_ALL_RISE;
               3, 4:    mode = TICK_ALL_FALL;
               5:       mode = TICK_NOISE;
               default: mode = TICK_MIXED;
            endcase
            run_left = $urandom_range(1, 8);
         end
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            case (mode)
               TICK_ALL_RISE: kind = ($urandom_range(0, 9) == 0) ? LANE_CRUISE : LANE_RISE;
               TICK_ALL_FALL: kind = ($urandom_range(0, 9) == 0) ? LANE_REST : LANE_FALL;
               TICK_NOISE:    kind = LANE_RAW;
               default:       kind = lane_kind_t'($urandom_range(0, 3));
            endcase
            make_lane(kind, lane_cur[i], lane_prev[i]);
         end
         push_lanes();
         run_left--;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, thr_type value, bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic program_regs(thr_type delta, thr_type stop, thr_type hold);
      settle();
      csr_write(CSR_SPARE_IDX, thr_type'($urandom), 1'b0);
      csr_write(CSR_DELTA_THR, delta, 1'b0);
      csr_write(CSR_STOP_THR, stop, 1'b0);
      csr_write(CSR_BOOST_HOLD, hold, 1'b1);
      cfg_delta = delta;
      cfg_stop  = stop;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_lanes('0, '0);                  push_lanes();
      set_lanes(24'h7FFFFF, '0);          push_lanes();
      set_lanes(24'h800000, 24'h7FFFFF);  push_lanes();
      set_lanes(24'h800000, '0);          push_lanes();
      set_lanes('0, 24'h800000);          push_lanes();
      lane_cur  = '{24'd1077, 24'd1076, 24'hFFFC65, 24'd924};
      lane_prev = '{24'd1000, 24'd1000, 24'd1000, 24'hFFFC18};
      push_lanes();
      lane_cur  = '{24'd256, 24'd257, 24'hFFFF00, 24'hFFFEFF};
      lane_prev = '{24'd256, 24'd257, 24'd300, 24'hFFFEFF};
      push_lanes();
      set_lanes(24'hFFFC18, 24'd1000);    push_lanes();
      set_lanes(24'hFFFFFF, '0);          push_lanes();
      set_lanes(24'hAAAAAA, 24'h555555);  push_lanes();
      set_lanes(24'h555555, 24'hAAAAAA);  push_lanes();
      settle();

      // Output held off while the input keeps offering back-to-back beats.
      src_idle_en   = 1'b0;
      long_hold_req = 1'b1;
      run_ticks(40);
      src_idle_en = 1'b1;
      run_ticks(160);

      program_regs('0, '0, '0);
      set_lanes('0, '0);                  push_lanes();
      set_lanes(24'h800000, 24'h800000);  push_lanes();
      run_ticks(200);

      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_ticks(150);

      program_regs(thr_type'($urandom_range(1, 300)), thr_type'($urandom_range(0, 2000)),
                   thr_type'($urandom_range(1, 6)));
      run_ticks(250);

      program_regs(thr_type'($urandom), thr_type'($urandom),
                   thr_type'($urandom_range(0, 40)));
      run_ticks(200);

      program_regs(DELTA_THR_RESET, STOP_THR_RESET, thr_type'(3));
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      run_ticks(250);
      settle();

      if (error_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mapc_pkg.sv
rtl/mapc_lane.sv
rtl/mapc_merge.sv
rtl/motor_accel_phase_classifier_core.sv
dv/motor_accel_phase_classifier_checker.sv
dv/tb_motor_accel_phase_classifier_core.sv
